>>> rtl/core/dqs_pkg.sv
package dqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_LIST       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] EM_OK    = 3'd0;
    localparam logic [2:0] EM_EMPTY = 3'd1;
    localparam logic [2:0] EM_FULL  = 3'd2;
    localparam logic [2:0] EM_DATA  = 3'd3;
    localparam logic [2:0] EM_FOUND = 3'd4;
    localparam logic [2:0] EM_LIST  = 3'd5;

    localparam logic [1:0] RD_FRONT = 2'd0;
    localparam logic [1:0] RD_BACK  = 2'd1;
    localparam logic [1:0] RD_IDX   = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       wr_front;
        logic       wr_back;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       pop_front;
        logic       pop_back;
        logic       idx_inc;
        logic       hit_acc;
        logic       emit;
        logic [2:0] emit_kind;
    } dqs_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                full;
        logic                idx_last;
        logic                out_free;
    } dqs_stat_t;

endpackage

>>> rtl/core/double_ended_queue_with_search_top.sv
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid/s_axis_tready  tuser: action; tdata: value
// m_axis   out        m_axis_tvalid/m_axis_tready  tuser: status, found; tdata: data_out;
//                                                  tlast: last
//
// Push and unused actions finish in the execute state. Pop of a non-empty queue adds a registered slot read.
// Search and list read one entry at a time, a read state and then a compare or wait state
// per entry, set by the single read port of the slot memory, and also wait on output stalls.
// Reset clears head, count, index, hit flag and output valid; slot contents are undefined until pushed.
// A result waits in the output register while the next item is taken.
module double_ended_queue_with_search_top
    import dqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // [31:0] value
    input  logic [7:0]          s_axis_tuser,   // [2:0] action, [7:3] zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // [31:0] data_out
    output logic [7:0]          m_axis_tuser,   // [1:0] status, [2] found, [7:3] zero
    output logic                m_axis_tlast
);

    dqs_cmd_t            cmd;
    dqs_stat_t           stat;
    logic [STATUS_W-1:0] out_status;
    logic                out_found;

    dqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dqs_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_action  (s_axis_tuser[ACTION_W-1:0]),
        .in_value   (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_data   (m_axis_tdata),
        .out_found  (out_found),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {5'd0, out_found, out_status};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while previous item still in progress");

    a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.empty && stat.full))
        else $error("queue flagged empty and full at once");

    a_found_is_plain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK
            && m_axis_tdata == '0 && m_axis_tlast)
        else $error("found flag on a result that is not a search result");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written over an untaken result");

endmodule

>>> rtl/core/dqs_ctrl.sv
module dqs_ctrl
    import dqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dqs_stat_t stat,
    output dqs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POPW  = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SCMP  = 3'd4;
    localparam logic [2:0] S_LRD   = 3'd5;
    localparam logic [2:0] S_LWAIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.action)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_kind = EM_FULL;
                            end
                            else
                            begin
                                cmd.emit_kind = EM_OK;
                                cmd.wr_front  = (stat.action == ACT_PUSH_FRONT);
                                cmd.wr_back   = (stat.action == ACT_PUSH_BACK);
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = (stat.action == ACT_POP_FRONT) ? RD_FRONT : RD_BACK;
                            state_next = S_POPW;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EM_EMPTY;
                            state_next    = S_IDLE;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_SRD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EM_OK;
                            state_next    = S_IDLE;
                        end
                    end
                    ACT_LIST:
                    begin
                        if (!stat.empty)
                        begin
                            state_next = S_LRD;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EM_EMPTY;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EM_OK;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end
            S_POPW:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_DATA;
                    cmd.pop_front = (stat.action == ACT_POP_FRONT);
                    cmd.pop_back  = (stat.action == ACT_POP_BACK);
                    state_next    = S_IDLE;
                end
            end
            S_SRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (!stat.idx_last)
                begin
                    cmd.hit_acc = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SRD;
                end
                else if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_FOUND;
                    state_next    = S_IDLE;
                end
            end
            S_LRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_LIST;
                    if (stat.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_LRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/dqs_dpath.sv
module dqs_dpath
    import dqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ACTION_W-1:0] in_action,
    input  logic [VALUE_W-1:0]  in_value,
    input  dqs_cmd_t            cmd,
    output dqs_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [VALUE_W-1:0]  out_data,
    output logic                out_found,
    output logic                out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] slots_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [AW-1:0]         idx_reg;
    logic                  hit_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [VALUE_W-1:0]    data_reg;
    logic [VALUE_W-1:0]    data_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  last_reg;
    logic                  last_next;

    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         tail_off;
    logic [AW-1:0]         back_off;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  match;
    logic                  out_free;

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign tail_off = count_reg[AW-1:0];
    assign back_off = AW'(count_reg - CW'(1));
    assign wr_addr  = cmd.wr_front ? head_dec : ring_pos(head_reg, tail_off);
    assign match    = (rdata_reg == word_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FRONT: rd_addr = head_reg;
            RD_BACK:  rd_addr = ring_pos(head_reg, back_off);
            default:  rd_addr = ring_pos(head_reg, idx_reg);
        endcase
    end

    assign stat.action   = action_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.idx_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign stat.out_free = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_front || cmd.wr_back)
        begin
            slots_reg[wr_addr] <= word_reg;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= slots_reg[rd_addr];
        end
        if (cmd.load_in)
        begin
            word_reg   <= DATA_WIDTH'(signed'(in_value));
            action_reg <= in_action;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.wr_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.wr_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            head_next  = ring_pos(head_reg, AW'(1));
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_back)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.load_in)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
                if (cmd.hit_acc)
                begin
                    hit_reg <= hit_reg || match;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        data_next   = '0;
        found_next  = 1'b0;
        last_next   = 1'b1;
        case (cmd.emit_kind)
            EM_EMPTY: status_next = ST_EMPTY;
            EM_FULL:  status_next = ST_FULL;
            EM_DATA:  data_next   = VALUE_W'(rdata_reg);
            EM_FOUND: found_next  = hit_reg || match;
            EM_LIST:
            begin
                data_next = VALUE_W'(rdata_reg);
                last_next = stat.idx_last;
            end
            default:  status_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            found_reg  <= found_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_found  = found_reg;
    assign out_last   = last_reg;

endmodule

>>> tb/sv/double_ended_queue_with_search_top_tb.sv
module double_ended_queue_with_search_top_tb;

    import dqs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 105;
    localparam int SETTLE_A     = 20;
    localparam int SETTLE_B     = 95;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 50;

    localparam logic [1:0] RX_OPEN   = 2'd0;
    localparam logic [1:0] RX_HALF   = 2'd1;
    localparam logic [1:0] RX_SPARSE = 2'd2;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [31:0]         value;
        bit                  settle;
    } deque_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [31:0]         data;
        logic                found;
        logic                last;
    } deque_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [7:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    logic        m_axis_tlast;

    deque_cmd_t   cmd_q[$];
    deque_reply_t awaited[$];
    logic [31:0]  shadow[$];

    logic [31:0] ring[DEPTH];
    int          front_idx = 0;
    int          fill = 0;

    logic in_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   items_taken = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    logic [1:0] stall_mode = RX_OPEN;
    int   mode_left = 0;
    int   mismatches = 0;

    double_ended_queue_with_search_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_deque_action(input logic [ACTION_W-1:0] act,
                                        input logic [31:0] val);
        deque_reply_t r;
        int           i;
        r = '{ST_OK, 32'd0, 1'b0, 1'b1};
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill == DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else if (act == ACT_PUSH_FRONT)
                begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    ring[front_idx] = val;
                    fill++;
                end
                else
                begin
                    ring[(front_idx + fill) % DEPTH] = val;
                    fill++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.data = ring[front_idx];
                    front_idx = (front_idx + 1) % DEPTH;
                    fill--;
                end
            end
            ACT_POP_BACK:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.data = ring[(front_idx + fill - 1) % DEPTH];
                    fill--;
                end
            end
            ACT_SEARCH:
            begin
                for (i = 0; i < fill; i++)
                begin
                    if (ring[(front_idx + i) % DEPTH] == val)
                    begin
                        r.found = 1'b1;
                    end
                end
            end
            ACT_LIST:
            begin
                if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (i = 0; i < fill - 1; i++)
                    begin
                        awaited.push_back('{ST_OK, ring[(front_idx + i) % DEPTH], 1'b0, 1'b0});
                    end
                    r.data = ring[(front_idx + fill - 1) % DEPTH];
                end
            end
            default:
            begin
            end
        endcase
        awaited.push_back(r);
    endtask

    task automatic queue_cmd(input logic [ACTION_W-1:0] act, input logic [31:0] val);
        deque_cmd_t c;
        c.action = act;
        c.value  = val;
        c.settle = (cmd_q.size() == SETTLE_A) || (cmd_q.size() == SETTLE_B);
        cmd_q.push_back(c);
        case (act)
            ACT_PUSH_FRONT:
                if (shadow.size() < DEPTH)
                    shadow.push_front(val);
            ACT_PUSH_BACK:
                if (shadow.size() < DEPTH)
                    shadow.push_back(val);
            ACT_POP_FRONT:
                if (shadow.size() != 0)
                    shadow.delete(0);
            ACT_POP_BACK:
                if (shadow.size() != 0)
                    shadow.delete(shadow.size() - 1);
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_probe();
        if (shadow.size() != 0 && $urandom_range(0, 1) == 1)
            return shadow[$urandom_range(0, shadow.size() - 1)];
        return rand_word();
    endfunction

    function automatic logic [ACTION_W-1:0] pick_push();
        return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    endfunction

    function automatic logic [ACTION_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
    endfunction

    initial
    begin
        int pick;
        queue_cmd(ACT_POP_FRONT, $urandom);
        queue_cmd(ACT_POP_BACK, $urandom);
        queue_cmd(ACT_LIST, $urandom);
        queue_cmd(ACT_SEARCH, 32'd0);
        queue_cmd(ACT_SPARE_6, $urandom);
        queue_cmd(ACT_SPARE_7, $urandom);
        queue_cmd(ACT_PUSH_FRONT, 32'h7fff_ffff);
        queue_cmd(ACT_PUSH_BACK, 32'h8000_0000);
        queue_cmd(ACT_PUSH_FRONT, 32'hffff_ffff);
        queue_cmd(ACT_PUSH_BACK, 32'h0000_0000);
        queue_cmd(ACT_SEARCH, 32'h8000_0000);
        queue_cmd(ACT_SEARCH, 32'h0000_0001);
        queue_cmd(ACT_LIST, $urandom);
        queue_cmd(ACT_POP_BACK, $urandom);
        queue_cmd(ACT_POP_FRONT, $urandom);
        queue_cmd(ACT_LIST, $urandom);
        queue_cmd(ACT_SEARCH, 32'h7fff_ffff);
        queue_cmd(ACT_POP_FRONT, $urandom);
        queue_cmd(ACT_POP_BACK, $urandom);
        queue_cmd(ACT_POP_FRONT, $urandom);

        while (cmd_q.size() < SETTLE_A + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                repeat (DEPTH - shadow.size() + $urandom_range(1, 2))
                    queue_cmd(pick_push(), rand_word());
                queue_cmd(ACT_SEARCH, pick_probe());
                queue_cmd(ACT_LIST, $urandom);
            end
            else if (pick == 2)
            begin
                repeat (shadow.size() + 1)
                    queue_cmd(pick_pop(), $urandom);
                queue_cmd(ACT_LIST, $urandom);
            end
            else
            begin
                repeat ($urandom_range(4, 12))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        queue_cmd(pick_push(), rand_word());
                    else if (pick < 64)
                        queue_cmd(pick_pop(), $urandom);
                    else if (pick < 82)
                        queue_cmd(ACT_SEARCH, pick_probe());
                    else if (pick < 94)
                        queue_cmd(ACT_LIST, $urandom);
                    else
                        queue_cmd($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7,
                                  $urandom);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        deque_cmd_t c;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_q.size() == 0 || (cmd_q[0].settle && awaited.size() != 0))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                c = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= c.value;
                s_axis_tuser  <= {5'd0, c.action};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 :
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) :
                                  $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= 2'($urandom_range(0, 2));
                mode_left  <= $urandom_range(8, 40);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        deque_reply_t want;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited.size() == 0)
            begin
                report_mismatch("unexpected item", m_axis_tdata, 32'd0);
            end
            else
            begin
                want = awaited.pop_front();
                if (m_axis_tuser[1:0] !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(want.status));
                if (m_axis_tdata !== want.data)
                    report_mismatch("data_out", m_axis_tdata, want.data);
                if (m_axis_tuser[2] !== want.found)
                    report_mismatch("found", 32'(m_axis_tuser[2]), 32'(want.found));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_deque_action(s_axis_tuser[ACTION_W-1:0], s_axis_tdata);
            items_taken <= items_taken + 1;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("** double_ended_queue_with_search_top: PASSED **");
        else
            $display("** double_ended_queue_with_search_top: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** double_ended_queue_with_search_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/core/dqs_pkg.sv
rtl/core/dqs_ctrl.sv
rtl/core/dqs_dpath.sv
rtl/core/double_ended_queue_with_search_top.sv
tb/sv/double_ended_queue_with_search_top_tb.sv
